@@ sv/debounced_door_inputs_service_gate_assert.svh @@
// Assertion macros shared by the debounce gate checker.
`ifndef DEBOUNCED_DOOR_INPUTS_SERVICE_GATE_ASSERT_SVH
`define DEBOUNCED_DOOR_INPUTS_SERVICE_GATE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define DDSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define DDSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ddsg_pkg.sv @@
// Shared types and constants of the debounce gate.
package ddsg_pkg;

  localparam int NUM_DOORS_DEF = 2;
  localparam int TIME_W        = 32;
  localparam int INTERVAL_W    = 16;

  localparam logic [INTERVAL_W-1:0] DEBOUNCE_RESET = 16'd50;

  localparam logic ACTION_INIT = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // What a debounce lane does with the current beat.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INIT,
    CMD_UPDATE
  } lane_cmd_t;

  // Block-wide flags of one result beat.
  typedef struct packed {
    logic ready;
    logic service_event;
    logic service_mode;
  } status_t;

endpackage

@@ sv/ddsg_lane.sv @@
// One debounce lane: stable level, candidate level and candidate timestamp.
module ddsg_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  ddsg_pkg::lane_cmd_t             cmd,
  input  logic                            active,
  input  logic [ddsg_pkg::TIME_W-1:0]     now_ms,
  input  logic [ddsg_pkg::INTERVAL_W-1:0] interval,
  output logic                            stable,
  output logic                            changed
);

  logic                        cand;
  logic [ddsg_pkg::TIME_W-1:0] since;
  logic [ddsg_pkg::TIME_W-1:0] since_next;
  logic [ddsg_pkg::TIME_W-1:0] elapsed;

  // A new level restarts the hold timer; the elapsed time wraps modulo 2^32.
  assign since_next = (active != cand) ? now_ms : since;
  assign elapsed    = now_ms - since_next;
  assign changed    = (active != stable) &&
                      (elapsed >= {{(ddsg_pkg::TIME_W-ddsg_pkg::INTERVAL_W){1'b0}}, interval});

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      cand   <= 1'b0;
      since  <= '0;
    end else begin
      unique case (cmd)
        ddsg_pkg::CMD_INIT: begin
          stable <= active;
          cand   <= active;
          since  <= now_ms;
        end
        ddsg_pkg::CMD_UPDATE: begin
          cand  <= active;
          since <= since_next;
          if (changed) begin
            stable <= active;
          end
        end
        ddsg_pkg::CMD_HOLD: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/ddsg_merge.sv @@
// Merging stage: turns lane findings into lane commands and the result beat.
module ddsg_merge #(
  parameter int NUM_DOORS = ddsg_pkg::NUM_DOORS_DEF
) (
  input  logic                  fire,
  input  logic                  action,
  input  logic                  svc_ok,
  input  logic                  svc_active,
  input  logic [NUM_DOORS-1:0]  door_active,
  input  logic [NUM_DOORS-1:0]  door_ok,
  input  logic                  is_ready,
  input  logic                  service_enabled,
  input  logic                  svc_stable,
  input  logic                  svc_changed,
  input  logic [NUM_DOORS-1:0]  door_stable,
  input  logic [NUM_DOORS-1:0]  door_flip,
  output ddsg_pkg::lane_cmd_t   svc_cmd,
  output ddsg_pkg::lane_cmd_t   door_cmd [NUM_DOORS],
  output ddsg_pkg::status_t     status,
  output logic [NUM_DOORS-1:0]  door_event,
  output logic [NUM_DOORS-1:0]  door_open
);

  always_comb begin
    logic chain;
    logic svc_new;
    logic resync;
    chain   = svc_ok;
    svc_new = svc_stable ^ svc_changed;
    resync  = svc_changed && !svc_new;
    svc_cmd = ddsg_pkg::CMD_HOLD;
    for (int i = 0; i < NUM_DOORS; i++) begin
      door_cmd[i] = ddsg_pkg::CMD_HOLD;
    end
    status.ready         = is_ready;
    status.service_event = 1'b0;
    status.service_mode  = service_enabled;
    door_event           = '0;
    door_open            = door_stable;

    if (fire && action == ddsg_pkg::ACTION_INIT) begin
      if (svc_ok) begin
        svc_cmd = ddsg_pkg::CMD_INIT;
        // Doors are set up in order; the first failed read stops the chain.
        for (int i = 0; i < NUM_DOORS; i++) begin
          chain = chain & door_ok[i];
          if (chain) begin
            door_cmd[i]  = ddsg_pkg::CMD_INIT;
            door_open[i] = door_active[i];
          end
        end
        if (chain) begin
          status.ready        = 1'b1;
          status.service_mode = svc_active;
        end
      end
    end else if (fire && is_ready && svc_ok) begin
      svc_cmd              = ddsg_pkg::CMD_UPDATE;
      status.service_event = svc_changed;
      if (svc_changed) begin
        status.service_mode = svc_new;
      end
      for (int i = 0; i < NUM_DOORS; i++) begin
        if (door_ok[i]) begin
          if (resync) begin
            door_cmd[i]  = ddsg_pkg::CMD_INIT;
            door_open[i] = door_active[i];
          end else begin
            door_cmd[i]   = ddsg_pkg::CMD_UPDATE;
            door_open[i]  = door_stable[i] ^ door_flip[i];
            door_event[i] = door_flip[i] && !service_enabled && !svc_changed;
          end
        end
      end
    end
  end

endmodule

@@ sv/debounced_door_inputs_service_gate.sv @@
// Top level of the debounce gate for one service switch and the door contacts.
//
// Usage: each input beat on in_valid/in_ready is an initialise sample (action 0)
// or a debounce tick (action 1) with a millisecond timestamp, the active-low
// raw levels and a read-ok flag for every input. Every input beat yields
// exactly one result beat on out_valid/out_ready.
// The debounce interval is written through cfg_valid/cfg_ready/cfg_data; the
// port is always ready and should be written only while the block is idle.
// Results are registered; the per-lane subtract and compare run in parallel,
// followed by the merging stage. Throughput is one beat per cycle while
// in_ready is high. The result sits in an output register backed by one skid
// register, so an input beat is still accepted while one result waits;
// in_ready falls only when both are full, that is once the receiver has
// stalled with two results held. Reset clears all debounce state, drops the
// internal ready and service mode flags, empties both result registers and
// restores the interval to 50 ms.
module debounced_door_inputs_service_gate #(
  parameter int NUM_DOORS = ddsg_pkg::NUM_DOORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [ddsg_pkg::TIME_W-1:0]     now_ms,
  input  logic                            service_level,
  input  logic                            service_read_ok,
  input  logic [NUM_DOORS-1:0]            door_levels,
  input  logic [NUM_DOORS-1:0]            door_read_ok,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ddsg_pkg::INTERVAL_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ready_res,
  output logic                            service_event,
  output logic                            service_mode,
  output logic [NUM_DOORS-1:0]            door_event,
  output logic [NUM_DOORS-1:0]            door_open
);

  logic [ddsg_pkg::INTERVAL_W-1:0] interval;
  logic                            is_ready;
  logic                            service_enabled;
  logic                            fire;

  ddsg_pkg::lane_cmd_t svc_cmd;
  ddsg_pkg::lane_cmd_t door_cmd [NUM_DOORS];
  logic                svc_stable;
  logic                svc_changed;
  logic [NUM_DOORS-1:0] door_stable;
  logic [NUM_DOORS-1:0] door_flip;
  logic [NUM_DOORS-1:0] door_active;

  ddsg_pkg::status_t    res_status;
  logic [NUM_DOORS-1:0] res_door_event;
  logic [NUM_DOORS-1:0] res_door_open;

  // Skid register holding a second result while the receiver stalls.
  logic                 skid_valid;
  ddsg_pkg::status_t    skid_status;
  logic [NUM_DOORS-1:0] skid_door_event;
  logic [NUM_DOORS-1:0] skid_door_open;

  assign in_ready    = !skid_valid;
  assign fire        = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign door_active = ~door_levels;

  // The service switch lane.
  ddsg_lane u_svc_lane (
    .clk      (clk),
    .rst      (rst),
    .cmd      (svc_cmd),
    .active   (~service_level),
    .now_ms   (now_ms),
    .interval (interval),
    .stable   (svc_stable),
    .changed  (svc_changed)
  );

  // One lane per door contact, all working on the same beat.
  for (genvar g = 0; g < NUM_DOORS; g++) begin : g_door
    ddsg_lane u_door_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (door_cmd[g]),
      .active   (door_active[g]),
      .now_ms   (now_ms),
      .interval (interval),
      .stable   (door_stable[g]),
      .changed  (door_flip[g])
    );
  end

  ddsg_merge #(
    .NUM_DOORS (NUM_DOORS)
  ) u_merge (
    .fire            (fire),
    .action          (action),
    .svc_ok          (service_read_ok),
    .svc_active      (~service_level),
    .door_active     (door_active),
    .door_ok         (door_read_ok),
    .is_ready        (is_ready),
    .service_enabled (service_enabled),
    .svc_stable      (svc_stable),
    .svc_changed     (svc_changed),
    .door_stable     (door_stable),
    .door_flip       (door_flip),
    .svc_cmd         (svc_cmd),
    .door_cmd        (door_cmd),
    .status          (res_status),
    .door_event      (res_door_event),
    .door_open       (res_door_open)
  );

  // Configuration and block-wide mode flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval        <= ddsg_pkg::DEBOUNCE_RESET;
      is_ready        <= 1'b0;
      service_enabled <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval <= cfg_data;
      end
      if (fire) begin
        is_ready        <= res_status.ready;
        service_enabled <= res_status.service_mode;
      end
    end
  end

  // Output register and skid register. A new result goes straight to the
  // output when it is free or being taken, otherwise it parks in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid     <= 1'b1;
          ready_res     <= skid_status.ready;
          service_event <= skid_status.service_event;
          service_mode  <= skid_status.service_mode;
          door_event    <= skid_door_event;
          door_open     <= skid_door_open;
          skid_valid    <= 1'b0;
        end else if (fire) begin
          out_valid     <= 1'b1;
          ready_res     <= res_status.ready;
          service_event <= res_status.service_event;
          service_mode  <= res_status.service_mode;
          door_event    <= res_door_event;
          door_open     <= res_door_open;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (fire) begin
        skid_valid      <= 1'b1;
        skid_status     <= res_status;
        skid_door_event <= res_door_event;
        skid_door_open  <= res_door_open;
      end
    end
  end

endmodule

@@ sv/ddsg_checker.sv @@
// Port-level checker of the debounce gate and its bind to the top level.
`include "debounced_door_inputs_service_gate_assert.svh"

module ddsg_checker #(
  parameter int NUM_DOORS = ddsg_pkg::NUM_DOORS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            ready_res,
  input logic                            service_event,
  input logic                            service_mode,
  input logic [NUM_DOORS-1:0]            door_event,
  input logic [NUM_DOORS-1:0]            door_open
);

  // The result registers come out of reset empty.
  `DDSG_ASSERT_IMPL(a_empty_after_reset, $past(rst), !out_valid,
                    "result beat right after reset")

  // A stalled result beat stays valid and keeps its door_open and service_mode.
  `DDSG_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(door_open) && $stable(service_mode),
                    "stalled result changed")

  // A service change can only be reported once the block is initialised.
  `DDSG_ASSERT_IMPL(a_event_needs_ready, out_valid && service_event, ready_res,
                    "service event while not ready")

  // A service change suppresses all door events of the same beat.
  `DDSG_ASSERT_IMPL(a_service_suppresses, out_valid && service_event, door_event == '0,
                    "door event beside service event")

  // Door events are never reported while service mode is on.
  `DDSG_ASSERT_IMPL(a_no_door_in_service, out_valid && (door_event != '0), !service_mode,
                    "door event in service mode")

endmodule

bind debounced_door_inputs_service_gate ddsg_checker #(
  .NUM_DOORS (NUM_DOORS)
) u_ddsg_checker (.*);

@@ tb/sv/tb_debounced_door_inputs_service_gate.sv @@
// Self-checking testbench for the debounce gate: directed table, random phases, in-line prediction.
module tb_debounced_door_inputs_service_gate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ND = ddsg_pkg::NUM_DOORS_DEF;
  localparam logic INIT_BEAT = ddsg_pkg::ACTION_INIT;
  localparam logic TICK_BEAT = ddsg_pkg::ACTION_TICK;
  // The receiver's deliberate long hold-off, in clock cycles.
  localparam int LONG_HOLD = 60;
  // Random beats per configuration phase; five phases give about 750 beats.
  localparam int PHASE_ITEMS = 150;

  // One input beat as the sender sees it.
  typedef struct packed {
    logic          act;
    logic [31:0]   now;
    logic          svc_level;
    logic          svc_ok;
    logic [ND-1:0] door_lvl;
    logic [ND-1:0] door_ok;
  } sample_t;

  // One result beat: the block-wide flags followed by the per-door fields.
  typedef struct packed {
    ddsg_pkg::status_t flags;
    logic [ND-1:0]     door_evt;
    logic [ND-1:0]     door_open;
  } gate_result_t;

  // A row of the directed table. Where typed is set, res holds the result that
  // is expected for the row; otherwise the predictor supplies it.
  typedef struct packed {
    sample_t      smp;
    bit           typed;
    gate_result_t res;
  } stim_row_t;

  // Debounce state of one input: settled level, level being watched, and the
  // millisecond time at which the watched level was first seen.
  typedef struct packed {
    logic        stable;
    logic        cand;
    logic [31:0] since;
  } lane_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          action = TICK_BEAT;
  logic [31:0]   now_ms = '0;
  logic          service_level = 1'b1;
  logic          service_read_ok = 1'b0;
  logic [ND-1:0] door_levels = '1;
  logic [ND-1:0] door_read_ok = '0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [ddsg_pkg::INTERVAL_W-1:0] cfg_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          ready_res;
  logic          service_event;
  logic          service_mode;
  logic [ND-1:0] door_event;
  logic [ND-1:0] door_open;

  // Predictor state, a mirror of the block's own debounce state.
  logic [ddsg_pkg::INTERVAL_W-1:0] hold_interval = ddsg_pkg::DEBOUNCE_RESET;
  logic                  gate_ready = 1'b0;
  logic                  gate_service = 1'b0;
  lane_t                 svc_lane = '0;
  lane_t                 door_lane [ND] = '{default: '0};

  // Results that the block still owes, oldest first.
  gate_result_t due_results [$];

  int error_count = 0;
  int hold_asked = 0;
  int hold_done = 0;
  bit quiet_run = 1'b0;

  debounced_door_inputs_service_gate #(
    .NUM_DOORS(ND)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .now_ms          (now_ms),
    .service_level   (service_level),
    .service_read_ok (service_read_ok),
    .door_levels     (door_levels),
    .door_read_ok    (door_read_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ready_res       (ready_res),
    .service_event   (service_event),
    .service_mode    (service_mode),
    .door_event      (door_event),
    .door_open       (door_open)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Seeding a lane puts both the settled and the watched level at the sample.
  function automatic lane_t lane_seed(logic active, logic [31:0] stamp);
    lane_t l;
    l.stable = active;
    l.cand   = active;
    l.since  = stamp;
    return l;
  endfunction

  // One debounce tick of a lane. The age is taken modulo 2^32, so a timestamp
  // that has wrapped past zero still measures the right distance.
  function automatic lane_t lane_track(lane_t l, logic active, logic [31:0] stamp);
    lane_t       n;
    logic [31:0] age;
    n = l;
    if (active != n.cand) begin
      n.cand  = active;
      n.since = stamp;
    end
    age = stamp - n.since;
    if (n.cand != n.stable && age >= {16'd0, hold_interval})
      n.stable = n.cand;
    return n;
  endfunction

  // Works out the result of one accepted beat and advances the mirrored state.
  function automatic gate_result_t debounce_outcome(sample_t s);
    gate_result_t  r;
    lane_t         nl;
    logic          svc_active;
    logic          all_ok;
    logic          svc_changed;
    logic [ND-1:0] ev;
    r           = '0;
    ev          = '0;
    svc_changed = 1'b0;
    all_ok      = 1'b1;
    svc_active  = ~s.svc_level;
    if (s.act == INIT_BEAT) begin
      // The service switch is seeded first, then the doors in order; the first
      // failed read stops the sequence and leaves the ready flag as it was.
      if (s.svc_ok) begin
        svc_lane = lane_seed(svc_active, s.now);
        for (int i = 0; i < ND; i++) begin
          if (!s.door_ok[i])
            all_ok = 1'b0;
          if (all_ok)
            door_lane[i] = lane_seed(~s.door_lvl[i], s.now);
        end
        if (all_ok) begin
          gate_service = svc_lane.stable;
          gate_ready   = 1'b1;
        end
      end
    end else if (gate_ready && s.svc_ok) begin
      nl          = lane_track(svc_lane, svc_active, s.now);
      svc_changed = (nl.stable != svc_lane.stable);
      svc_lane    = nl;
      if (svc_changed) begin
        gate_service = svc_lane.stable;
        // Leaving service mode takes the doors afresh from this very sample.
        if (!gate_service) begin
          for (int i = 0; i < ND; i++)
            if (s.door_ok[i])
              door_lane[i] = lane_seed(~s.door_lvl[i], s.now);
        end
      end
      for (int i = 0; i < ND; i++) begin
        if (s.door_ok[i]) begin
          nl = lane_track(door_lane[i], ~s.door_lvl[i], s.now);
          if (nl.stable != door_lane[i].stable && !gate_service && !svc_changed)
            ev[i] = 1'b1;
          door_lane[i] = nl;
        end
      end
    end
    r.flags.ready         = gate_ready;
    r.flags.service_event = svc_changed;
    r.flags.service_mode  = gate_service;
    r.door_evt            = ev;
    for (int i = 0; i < ND; i++)
      r.door_open[i] = door_lane[i].stable;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic act, logic [31:0] stamp, logic svl,
                                         logic sok, logic [ND-1:0] dl,
                                         logic [ND-1:0] dok, bit typed, logic rdy,
                                         logic sev, logic smode, logic [ND-1:0] dev,
                                         logic [ND-1:0] dop);
    stim_row_t row;
    row.smp.act                 = act;
    row.smp.now                 = stamp;
    row.smp.svc_level           = svl;
    row.smp.svc_ok              = sok;
    row.smp.door_lvl            = dl;
    row.smp.door_ok             = dok;
    row.typed                   = typed;
    row.res.flags.ready         = rdy;
    row.res.flags.service_event = sev;
    row.res.flags.service_mode  = smode;
    row.res.door_evt            = dev;
    row.res.door_open           = dop;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Offers one beat and holds it until the block takes it. The expectation is
  // queued at the accepting edge, so it always precedes its own result.
  task automatic offer_sample(stim_row_t row);
    gate_result_t predicted;
    in_valid        <= 1'b1;
    action          <= row.smp.act;
    now_ms          <= row.smp.now;
    service_level   <= row.smp.svc_level;
    service_read_ok <= row.smp.svc_ok;
    door_levels     <= row.smp.door_lvl;
    door_read_ok    <= row.smp.door_ok;
    do @(posedge clk); while (!in_ready);
    predicted = debounce_outcome(row.smp);
    due_results.push_back(row.typed ? row.res : predicted);
  endtask

  // Random gap after an accepted beat; none in the closing phase.
  task automatic sender_gap();
    if (!quiet_run && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Writes the debounce interval; the predictor takes it at the same edge.
  task automatic write_interval(logic [ddsg_pkg::INTERVAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    hold_interval = value;
    cfg_valid <= 1'b0;
  endtask

  // Receiver. It mostly takes every beat, stalls in random bursts, and once,
  // on request from the sender, makes one long hold-off so that both result
  // registers fill and in_ready has to fall.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
        out_ready <= 1'b1;
      end else if (!quiet_run && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result beat is checked field by field against the oldest expectation.
  always @(posedge clk) begin : result_check
    gate_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result beat with no expectation",
                        32'({ready_res, service_event, service_mode, door_event, door_open}),
                        32'd0);
      end else begin
        want = due_results.pop_front();
        if (ready_res !== want.flags.ready)
          report_mismatch("ready_res", 32'(ready_res), 32'(want.flags.ready));
        if (service_event !== want.flags.service_event)
          report_mismatch("service_event", 32'(service_event),
                          32'(want.flags.service_event));
        if (service_mode !== want.flags.service_mode)
          report_mismatch("service_mode", 32'(service_mode), 32'(want.flags.service_mode));
        if (door_event !== want.door_evt)
          report_mismatch("door_event", 32'(door_event), 32'(want.door_evt));
        if (door_open !== want.door_open)
          report_mismatch("door_open", 32'(door_open), 32'(want.door_open));
      end
    end
  end

  // Generous bound on the whole run, far beyond the slowest correct one.
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    stim_row_t             directed [$];
    stim_row_t             row;
    logic [ddsg_pkg::INTERVAL_W-1:0] phase_interval [5];
    logic [31:0]           now_track;
    logic                  svc_track;
    logic [ND-1:0]         door_track;
    int                    pick;
    int                    flip;
    int                    step_max;

    // Directed table, run with the reset interval of 50 ms. The first rows
    // are typed in: before the first good initialise nothing can be set, and
    // a partial initialise leaves only the lanes it reached.
    // Tick while not yet initialised.
    directed.push_back(stim_row(TICK_BEAT, 32'd0, 1'b1, 1'b1, 2'b11, 2'b11,
                                1'b1, 1'b0, 1'b0, 1'b0, 2'b00, 2'b00));
    // Initialise with a failed service read: nothing at all happens.
    directed.push_back(stim_row(INIT_BEAT, 32'd100, 1'b0, 1'b0, 2'b00, 2'b11,
                                1'b1, 1'b0, 1'b0, 1'b0, 2'b00, 2'b00));
    // Initialise that stops at door 0.
    directed.push_back(stim_row(INIT_BEAT, 32'd200, 1'b1, 1'b1, 2'b11, 2'b10,
                                1'b1, 1'b0, 1'b0, 1'b0, 2'b00, 2'b00));
    // Initialise that seeds door 0 as open and then stops at door 1.
    directed.push_back(stim_row(INIT_BEAT, 32'd300, 1'b1, 1'b1, 2'b00, 2'b01,
                                1'b1, 1'b0, 1'b0, 1'b0, 2'b00, 2'b01));
    // Good initialise just below the wrap of the millisecond counter.
    directed.push_back(stim_row(INIT_BEAT, 32'hFFFF_FFC0, 1'b1, 1'b1, 2'b01, 2'b11,
                                1'b1, 1'b1, 1'b0, 1'b0, 2'b00, 2'b10));
    // Door 0 starts to open, then settles after the counter has wrapped.
    directed.push_back(stim_row(TICK_BEAT, 32'hFFFF_FFCA, 1'b1, 1'b1, 2'b00, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0010, 1'b1, 1'b1, 2'b00, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // A failed service read skips the whole tick, door changes included.
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0020, 1'b0, 1'b0, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // Door 1 read fails; door 0 closes exactly at the interval, not one ms early.
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0030, 1'b1, 1'b1, 2'b11, 2'b01,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0061, 1'b1, 1'b1, 2'b11, 2'b01,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0062, 1'b1, 1'b1, 2'b11, 2'b01,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // Service switch and door 1 change together; the door event is swallowed
    // on the tick where service mode is entered.
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0100, 1'b0, 1'b1, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0140, 1'b0, 1'b1, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // In service mode a door still settles but reports no event.
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0150, 1'b0, 1'b1, 2'b10, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0190, 1'b0, 1'b1, 2'b10, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // Leaving service mode reseeds the readable doors from the same sample.
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_01A0, 1'b1, 1'b1, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_01E0, 1'b1, 1'b1, 2'b00, 2'b01,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    // Extremes of every field, and an initialise straight into service mode.
    directed.push_back(stim_row(TICK_BEAT, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(INIT_BEAT, 32'h0000_0000, 1'b0, 1'b1, 2'b00, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(TICK_BEAT, 32'h0000_0001, 1'b1, 1'b1, 2'b01, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    directed.push_back(stim_row(INIT_BEAT, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'b11, 2'b11,
                                1'b0, 1'b0, 1'b0, 1'b0, '0, '0));

    phase_interval[0] = 16'd0;
    phase_interval[1] = 16'hFFFF;
    phase_interval[2] = 16'd1;
    phase_interval[3] = 16'($urandom_range(2, 65534));
    phase_interval[4] = ddsg_pkg::DEBOUNCE_RESET;

    // Synchronous reset at the start, applied once only.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      offer_sample(directed[k]);
      sender_gap();
    end

    now_track  = $urandom();
    svc_track  = 1'b1;
    door_track = '1;

    // Random phases, each under its own interval. A phase mostly drifts the
    // levels slowly so that they settle, with wrapping time, occasional time
    // jumps, initialise beats, failed reads and short glitches as noise.
    for (int p = 0; p < 5; p++) begin
      in_valid <= 1'b0;
      wait_results_drained();
      // The block is idle once the last result is out; the extra wait below is
      // spare margin.
      repeat (2) @(posedge clk);
      write_interval(phase_interval[p]);
      if (p == 4)
        quiet_run = 1'b1;
      step_max = int'(hold_interval) / 3 + 3;
      // Resynchronise the service switch and the doors so each phase starts from
      // a clean initialise.
      row = stim_row(INIT_BEAT, now_track, svc_track, 1'b1, door_track, '1,
                     1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
      offer_sample(row);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (p == 1 && k == 40)
          hold_asked++;
        if (p == 2 && k == 75) begin
          // The sender stops until the block has handed over everything.
          in_valid <= 1'b0;
          wait_results_drained();
          @(posedge clk);
        end
        if (pick < 4)
          now_track = $urandom();
        else
          now_track += 32'($urandom_range(0, step_max));
        if ($urandom_range(0, 15) == 0)
          svc_track = ~svc_track;
        if ($urandom_range(0, 4) == 0) begin
          flip = $urandom_range(0, ND - 1);
          door_track[flip] = ~door_track[flip];
        end
        row = stim_row((pick >= 4 && pick < 8) ? INIT_BEAT : TICK_BEAT, now_track,
                       svc_track, ($urandom_range(0, 19) != 0), door_track, '1,
                       1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
        if (pick >= 8 && pick < 12)
          row.smp.door_lvl = ND'($urandom());
        if ($urandom_range(0, 24) == 0)
          row.smp.svc_level = ~row.smp.svc_level;
        for (int b = 0; b < ND; b++)
          row.smp.door_ok[b] = ($urandom_range(0, 9) != 0);
        offer_sample(row);
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    wait_results_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
